// ===== hdl/crt_rc_pkg.sv =====
// Shared types, constants and codes for the CRT recombine-and-carry block.
// No dependencies; every other file imports this package.
package crt_rc_pkg;

	localparam int RES_W      = 62;   // residue, modulus and inverse width
	localparam int LIMB_W     = 64;
	localparam int IDX_W      = 16;   // limb_index port width
	localparam int LIM_W      = 17;   // limb_limit and window base width
	localparam int OFF_W      = 6;    // bit offset inside window[0]
	localparam int CNT_W      = 6;    // step counter, covers RES_W steps
	localparam int C_W        = 125;  // rebuilt coefficient, d*P0 + r0 < 2^125
	localparam int HALF_W     = 32;   // multiplier operand width
	localparam int WIN_DEPTH  = 4;
	localparam int WIN_IDX_W  = 2;
	localparam int SHIFT_BITS = 45;
	localparam int MAX_LIMBS  = 65536;

	localparam logic [LIM_W-1:0] BASE_MAX  = '1;
	localparam logic [CNT_W-1:0] LAST_BIT  = CNT_W'(RES_W - 1);
	localparam logic [CNT_W-1:0] LAST_PP   = CNT_W'(4);
	localparam logic [CNT_W-1:0] LAST_LIMB = CNT_W'(WIN_DEPTH - 1);

	typedef enum logic [1:0] {
		REG_MODULUS_A,
		REG_MODULUS_B,
		REG_INVERSE,
		REG_LIMB_LIMIT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SLIDE,
		OP_MOD_A,
		OP_SAVE,
		OP_MOD_B,
		OP_DIFF,
		OP_MM_DBL,
		OP_MM_ADD,
		OP_MUL,
		OP_ADD,
		OP_FLUSH
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SLIDE,
		S_MOD_A,
		S_SAVE,
		S_MOD_B,
		S_DIFF,
		S_MM_DBL,
		S_MM_ADD,
		S_MUL,
		S_ADD,
		S_FLUSH
	} ctl_state_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CNT_W-1:0] cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic             pend;
		logic             out_free;
		logic             final_coeff;
		logic [OFF_W-1:0] off;
	} dp_stat_t;

endpackage

// ===== hdl/crt_rc_if.sv =====
// Valid/ready channel interfaces: coefficient residues in, finished limbs out.
// Depends on crt_rc_pkg.
interface crt_rc_in_if
	import crt_rc_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] residue_a;
	logic [RES_W-1:0] residue_b;
	logic             final_coeff;

	modport source (output valid, residue_a, residue_b, final_coeff, input ready);
	modport sink   (input valid, residue_a, residue_b, final_coeff, output ready);
endinterface

interface crt_rc_out_if
	import crt_rc_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [LIMB_W-1:0] limb_value;
	logic [IDX_W-1:0]  limb_index;
	logic              run_end;

	modport source (output valid, limb_value, limb_index, run_end, input ready);
	modport sink   (input valid, limb_value, limb_index, run_end, output ready);
endinterface

// ===== hdl/crt_rc_ctrl.sv =====
// Controller: sequences load, slide, residue reduction, Garner multiply,
// coefficient multiply, window add and flush. Depends on crt_rc_pkg.
module crt_rc_ctrl
	import crt_rc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t       state_q, state_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cnt_nx   = cnt_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.cnt  = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = S_SLIDE;
					cnt_nx   = '0;
				end
			end
			S_SLIDE: begin
				if (!stat.pend) begin
					state_nx = S_MOD_A;
				end else if (stat.out_free) begin
					cmd.op   = OP_SLIDE;
					state_nx = S_MOD_A;
				end
			end
			S_MOD_A: begin
				cmd.op = OP_MOD_A;
				if (cnt_q == LAST_BIT) begin
					state_nx = S_SAVE;
					cnt_nx   = '0;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			S_SAVE: begin
				cmd.op   = OP_SAVE;
				state_nx = S_MOD_B;
			end
			S_MOD_B: begin
				cmd.op = OP_MOD_B;
				if (cnt_q == LAST_BIT) begin
					state_nx = S_DIFF;
					cnt_nx   = '0;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			S_DIFF: begin
				cmd.op   = OP_DIFF;
				state_nx = S_MM_DBL;
			end
			S_MM_DBL: begin
				cmd.op   = OP_MM_DBL;
				state_nx = S_MM_ADD;
			end
			S_MM_ADD: begin
				cmd.op = OP_MM_ADD;
				if (cnt_q == LAST_BIT) begin
					state_nx = S_MUL;
					cnt_nx   = '0;
				end else begin
					state_nx = S_MM_DBL;
					cnt_nx   = cnt_q + 1'b1;
				end
			end
			S_MUL: begin
				cmd.op = OP_MUL;
				if (cnt_q == LAST_PP) begin
					state_nx = S_ADD;
					cnt_nx   = '0;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			S_ADD: begin
				cmd.op = OP_ADD;
				if (cnt_q == LAST_LIMB) begin
					state_nx = stat.final_coeff ? S_FLUSH : S_IDLE;
					cnt_nx   = '0;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.op = OP_FLUSH;
					if (cnt_q == LAST_LIMB) begin
						state_nx = S_IDLE;
						cnt_nx   = '0;
					end else begin
						cnt_nx = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
				cnt_nx   = '0;
			end
		endcase
	end

endmodule

// ===== hdl/crt_rc_dp.sv =====
// Datapath: config registers, shared modular reduce/multiply unit, 32x32
// multiplier, four-limb window and output register. Depends on crt_rc_pkg.
module crt_rc_dp
	import crt_rc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_reg_t          cfg_index,
	input  logic [RES_W-1:0]  cfg_data,
	input  logic [RES_W-1:0]  residue_a,
	input  logic [RES_W-1:0]  residue_b,
	input  logic              final_coeff,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LIMB_W-1:0] limb_value,
	output logic [IDX_W-1:0]  limb_index,
	output logic              run_end
);

	logic [RES_W-1:0] mod_a_q, mod_b_q, inv_q;
	logic [LIM_W-1:0] limit_q;

	logic [RES_W-1:0] r0_q, r1_q, rem_q, ra_q, diff_q, acc_q;
	logic             final_q;
	logic [C_W-1:0]   c_q;
	logic [2*HALF_W-1:0] pp_q;
	logic [1:0]       pp_k_q;

	logic [LIMB_W-1:0] win_q [WIN_DEPTH];
	logic [LIM_W-1:0]  base_q;
	logic [OFF_W-1:0]  off_q;
	logic              pend_q;
	logic              cy_q;

	logic              out_valid_q;
	logic [LIMB_W-1:0] out_value_q;
	logic [IDX_W-1:0]  out_index_q;
	logic              out_end_q;

	// effective limit = min(limb_limit, MAX_LIMBS)
	logic [LIM_W+1:0] lim_eff;
	always_comb begin
		if ((LIM_W+2)'(limit_q) < (LIM_W+2)'(MAX_LIMBS))
			lim_eff = (LIM_W+2)'(limit_q);
		else
			lim_eff = (LIM_W+2)'(MAX_LIMBS);
	end

	// bit pick for the serial reduce and multiply passes, MSB first
	logic [CNT_W-1:0] bit_idx;
	logic             mod_bit, inv_bit;
	assign bit_idx = LAST_BIT - cmd.cnt;
	assign mod_bit = (cmd.op == OP_MOD_B) ? r1_q[bit_idx] : r0_q[bit_idx];
	assign inv_bit = inv_q[bit_idx];

	logic [RES_W:0] m_ext, shl, mod_nx, dbl, dbl_nx, madd, madd_nx, dsum;
	assign m_ext   = {1'b0, mod_b_q};
	assign shl     = {rem_q, mod_bit};
	assign mod_nx  = (shl >= m_ext) ? shl - m_ext : shl;
	assign dbl     = {acc_q, 1'b0};
	assign dbl_nx  = (dbl >= m_ext) ? dbl - m_ext : dbl;
	assign madd    = {1'b0, acc_q} + {1'b0, diff_q};
	assign madd_nx = (madd >= m_ext) ? madd - m_ext : madd;
	assign dsum    = {1'b0, rem_q} + m_ext - {1'b0, ra_q};

	// partial products of d * P0, one 32x32 per cycle
	logic [HALF_W-1:0]   mx, my;
	logic [1:0]          pp_sh;
	logic [4*HALF_W-1:0] pp_wide;
	assign mx      = cmd.cnt[0] ? HALF_W'(acc_q[RES_W-1:HALF_W]) : acc_q[HALF_W-1:0];
	assign my      = cmd.cnt[1] ? HALF_W'(mod_a_q[RES_W-1:HALF_W]) : mod_a_q[HALF_W-1:0];
	assign pp_sh   = 2'(pp_k_q[0]) + 2'(pp_k_q[1]);
	assign pp_wide = (4*HALF_W)'(pp_q) << (HALF_W * pp_sh);

	// window add, one limb per cycle
	logic [WIN_IDX_W-1:0]  wi;
	logic [3*LIMB_W-1:0]   a_full;
	logic [LIMB_W-1:0]     a_limb;
	logic                  cy_in;
	logic [LIMB_W:0]       wsum;
	logic [OFF_W:0]        off_nx;
	assign wi     = cmd.cnt[WIN_IDX_W-1:0];
	assign a_full = (3*LIMB_W)'(c_q) << off_q;
	assign a_limb = (wi == WIN_IDX_W'(WIN_DEPTH - 1)) ? '0 : a_full[LIMB_W*wi +: LIMB_W];
	assign cy_in  = (wi == '0) ? 1'b0 : cy_q;
	assign wsum   = {1'b0, win_q[wi]} + {1'b0, a_limb} + (LIMB_W+1)'(cy_in);
	assign off_nx = {1'b0, off_q} + (OFF_W+1)'(SHIFT_BITS);

	// limb emission
	logic [LIM_W-1:0] base_inc;
	logic [LIM_W+1:0] fidx;
	logic             slide_emit, flush_emit, out_free;
	assign base_inc   = (base_q < BASE_MAX) ? base_q + 1'b1 : base_q;
	assign fidx       = (LIM_W+2)'(base_q) + (LIM_W+2)'(wi);
	assign slide_emit = (cmd.op == OP_SLIDE) && ((LIM_W+2)'(base_q) < lim_eff);
	assign flush_emit = (cmd.op == OP_FLUSH) && (fidx < lim_eff);
	assign out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_a_q <= RES_W'(2);
			mod_b_q <= RES_W'(2);
			inv_q   <= '0;
			limit_q <= LIM_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS_A:  mod_a_q <= cfg_data;
				REG_MODULUS_B:  mod_b_q <= cfg_data;
				REG_INVERSE:    inv_q   <= cfg_data;
				REG_LIMB_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				r0_q    <= residue_a;
				r1_q    <= residue_b;
				final_q <= final_coeff;
				rem_q   <= '0;
			end
			OP_MOD_A, OP_MOD_B: rem_q <= mod_nx[RES_W-1:0];
			OP_SAVE: begin
				ra_q  <= rem_q;
				rem_q <= '0;
			end
			OP_DIFF: begin
				if (mod_b_q == '0)
					diff_q <= '0;
				else if (rem_q >= ra_q)
					diff_q <= rem_q - ra_q;
				else
					diff_q <= dsum[RES_W-1:0];
				acc_q  <= '0;
				c_q    <= C_W'(r0_q);
				pp_q   <= '0;
				pp_k_q <= '0;
			end
			OP_MM_DBL: acc_q <= dbl_nx[RES_W-1:0];
			OP_MM_ADD: begin
				if (inv_bit)
					acc_q <= madd_nx[RES_W-1:0];
			end
			OP_MUL: begin
				c_q    <= c_q + pp_wide[C_W-1:0];
				pp_q   <= mx * my;
				pp_k_q <= cmd.cnt[1:0];
			end
			OP_ADD: cy_q <= wsum[LIMB_W];
			default: ;
		endcase
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++)
				win_q[i] <= '0;
			base_q <= '0;
			off_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_SLIDE: begin
					for (int i = 0; i < WIN_DEPTH - 1; i++)
						win_q[i] <= win_q[i+1];
					win_q[WIN_DEPTH-1] <= '0;
					base_q <= base_inc;
					pend_q <= 1'b0;
				end
				OP_ADD: begin
					win_q[wi] <= wsum[LIMB_W-1:0];
					if (wi == WIN_IDX_W'(WIN_DEPTH - 1)) begin
						off_q  <= off_nx[OFF_W-1:0];
						pend_q <= off_nx[OFF_W];
					end
				end
				OP_FLUSH: begin
					if (wi == WIN_IDX_W'(WIN_DEPTH - 1)) begin
						for (int i = 0; i < WIN_DEPTH; i++)
							win_q[i] <= '0;
						base_q <= '0;
						off_q  <= '0;
						pend_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (slide_emit || flush_emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (slide_emit) begin
			out_value_q <= win_q[0];
			out_index_q <= base_q[IDX_W-1:0];
			// last of the item unless the flush that follows emits something
			out_end_q   <= !(final_q && ((LIM_W+2)'(base_inc) < lim_eff));
		end else if (flush_emit) begin
			out_value_q <= win_q[wi];
			out_index_q <= fidx[IDX_W-1:0];
			out_end_q   <= (wi == WIN_IDX_W'(WIN_DEPTH - 1)) || (fidx + 1'b1 >= lim_eff);
		end
	end

	assign stat.pend        = pend_q;
	assign stat.out_free    = out_free;
	assign stat.final_coeff = final_q;
	assign stat.off         = off_q;

	assign out_valid  = out_valid_q;
	assign limb_value = out_value_q;
	assign limb_index = out_index_q;
	assign run_end    = out_end_q;

endmodule

// ===== hdl/crt_recombine_carry.sv =====
// Top level of the two-modulus CRT recombine with carry into 64-bit limbs.
// Depends on crt_rc_pkg, crt_rc_if, crt_rc_ctrl and crt_rc_dp.
//
//  channel   dir  handshake      payload
//  coeff     in   valid/ready    residue_a[61:0] residue_b[61:0] final_coeff
//  limb      out  valid/ready    limb_value[63:0] limb_index[15:0] run_end
//  cfg       in   cfg_we         cfg_index[1:0] cfg_data[61:0]
//
// An item runs in order through the accept step, the slide step, two 62-step
// bit-serial reductions with a save step and a difference step, a bit-serial
// shift-and-add modular multiply, the partial products on the 32x32
// multiplier and the window limb adds, all on one shared datapath.
// A final item adds a flush step for each window limb. A new item is taken only in idle.
// A stalled limb output holds the block only at the slide step and in flush.
// Reset at once clears the window and sets the config and control registers to their defaults.
module crt_recombine_carry
	import crt_rc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_reg_t         cfg_index,
	input  logic [RES_W-1:0] cfg_data,
	crt_rc_in_if.sink        coeff,
	crt_rc_out_if.source     limb
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	crt_rc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (coeff.valid),
		.in_ready (coeff.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crt_rc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.residue_a   (coeff.residue_a),
		.residue_b   (coeff.residue_b),
		.final_coeff (coeff.final_coeff),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (limb.valid),
		.out_ready   (limb.ready),
		.limb_value  (limb.limb_value),
		.limb_index  (limb.limb_index),
		.run_end     (limb.run_end)
	);

	// busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		coeff.valid && coeff.ready |=> !coeff.ready)
		else $error("item accepted while previous item in flight");

	// a pending slide always leaves the offset below one shift step
	a_pend_offset: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pend |-> (stat.off < OFF_W'(SHIFT_BITS)))
		else $error("slide pending with offset out of range");

	// the window only moves while the controller is busy
	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		coeff.ready |-> cmd.op == OP_NONE || cmd.op == OP_LOAD)
		else $error("datapath command issued in idle");

endmodule
